// ===== hw/rtl/rpa_pkg.sv =====
// rpa_pkg: shared types, constants and codes for the radial power average block
// used by rpa_ctrl, rpa_dp and radial_power_average; no dependencies
`timescale 1ns / 1ps
package rpa_pkg;

  localparam int DEF_MAX_BINS = 512;

  localparam int COORD_W = 10;
  localparam int MAG_W   = 10;
  localparam int SQ_W    = 19;
  localparam int ASP_W   = 17;
  localparam int NB_W    = 10;
  localparam int PW_W    = 32;
  localparam int IDX_W   = 9;
  localparam int SUM_W   = 53;
  localparam int CNT_W   = 21;
  localparam int Q_W     = 38;
  localparam int RV_W    = 24;
  localparam int RES_W   = 12;
  localparam int REM_W   = 15;
  localparam int ROOT_STEPS = RV_W / 2;
  localparam int DIVC_W  = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W   = 17;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ASPECT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_BINS = 2'd2;

  localparam logic KIND_ACC  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SQ, S_MUL, S_ROOT, S_LOOK, S_ACC,
    S_RLOOK, S_RWAIT, S_DIV, S_RFIN
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load_in;
    logic do_sq;
    logic do_mul;
    logic root_step;
    logic mem_rd;
    logic acc_wr;
    logic div_start;
    logic div_step;
    logic zero_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic kind;
    logic root_done;
    logic bin_ok;
    logic cnt_full;
    logic div_done;
  } status_t;

endpackage

// ===== hw/rtl/rpa_ctrl.sv =====
// rpa_ctrl: sequencer for clearing, accumulate and read-and-clear items
// depends on rpa_pkg
`timescale 1ns / 1ps
module rpa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  rpa_pkg::status_t sts,
  output rpa_pkg::cmd_t    cmd
);
  import rpa_pkg::*;

  state_t state, state_next;
  logic   slot_free;

  assign slot_free = !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (sts.clr_done) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_SQ;
      S_SQ: begin
        // kind is registered at accept
        if (sts.kind == KIND_READ) state_next = S_RLOOK;
        else state_next = S_MUL;
      end
      S_MUL:   state_next = S_ROOT;
      S_ROOT:  if (sts.root_done) state_next = S_LOOK;
      S_LOOK:  state_next = sts.bin_ok ? S_ACC : S_IDLE;
      S_ACC:   state_next = S_IDLE;
      S_RLOOK: state_next = S_RWAIT;
      S_RWAIT: state_next = S_DIV;
      S_DIV:   if (sts.div_done) state_next = S_RFIN;
      S_RFIN:  if (slot_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_CLEAR: cmd.clr_step = !sts.clr_done;
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      S_SQ:    cmd.do_sq = 1'b1;
      S_MUL:   cmd.do_mul = 1'b1;
      S_ROOT:  cmd.root_step = !sts.root_done;
      S_LOOK:  cmd.mem_rd = sts.bin_ok;
      S_ACC:   cmd.acc_wr = !sts.cnt_full;
      S_RLOOK: cmd.mem_rd = 1'b1;
      S_RWAIT: cmd.div_start = 1'b1;
      S_DIV:   cmd.div_step = !sts.div_done;
      S_RFIN: begin
        cmd.out_load = slot_free;
        cmd.zero_wr  = slot_free;
      end
      default: cmd = '0;
    endcase
  end

  a_no_access_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !cmd.mem_rd && !cmd.acc_wr && !cmd.zero_wr)
    else $error("bin access during clearing pass");
  a_acc_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_wr |-> $past(cmd.mem_rd))
    else $error("bin update without prior read");
  a_load_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");
  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RFIN))
    else $error("result raised outside read finish");

endmodule

// ===== hw/rtl/rpa_dp.sv =====
// rpa_dp: radius arithmetic, iterative square root and divider, bin memory
// depends on rpa_pkg
`timescale 1ns / 1ps
module rpa_dp #(
  parameter int MAX_BINS = rpa_pkg::DEF_MAX_BINS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rpa_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               kind,
  input  logic signed [rpa_pkg::COORD_W-1:0] freq_x,
  input  logic signed [rpa_pkg::COORD_W-1:0] freq_y,
  input  logic [rpa_pkg::PW_W-1:0]           power,
  input  logic [rpa_pkg::IDX_W-1:0]          bin_index,
  input  rpa_pkg::cmd_t                      cmd,
  output rpa_pkg::status_t                   sts,
  output logic [rpa_pkg::PW_W-1:0]           bin_average,
  output logic [rpa_pkg::CNT_W-1:0]          bin_count,
  output logic [rpa_pkg::IDX_W-1:0]          bin_echo
);
  import rpa_pkg::*;

  localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int IW = ((AW > RES_W) ? AW : RES_W) + 1;
  localparam int MW = SUM_W + CNT_W;
  localparam logic [IW-1:0] BINS_EXT = IW'(MAX_BINS);

  logic             scale_x;
  logic [ASP_W-1:0] aspect;
  logic [NB_W-1:0]  nbins;

  logic             kind_r;
  logic [MAG_W-1:0] ax, ay;
  logic [PW_W-1:0]  pw_r;
  logic [IDX_W-1:0] idx_r;
  logic             rd_ok;
  logic [SQ_W-1:0]  ax2, ay2;
  logic [RV_W-1:0]  root_val;
  logic [REM_W-1:0] root_rem;
  logic [RES_W-1:0] root_res;
  logic [3:0]       root_cnt;
  logic [MW-1:0]    mem [MAX_BINS];
  logic [AW-1:0]    acc_addr;
  logic [SUM_W-1:0] rd_sum;
  logic [CNT_W-1:0] rd_cnt;
  logic [CNT_W:0]   div_rem;
  logic [SUM_W-1:0] div_num, div_q;
  logic [DIVC_W-1:0] div_cnt;
  logic [AW:0]      clr_cnt;

  logic [MAG_W-1:0] mx, my;
  logic [Q_W-1:0]   q_full;
  logic [REM_W-1:0] rem_sh, trial;
  logic [RES_W:0]   res_inc;
  logic [IW-1:0]    bin_ext, idx_ext;
  logic [AW-1:0]    rd_addr;
  logic [CNT_W:0]   drem_sh;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [MW-1:0]    wr_data;

  // two's complement magnitude, -512 gives 512
  assign mx = freq_x[COORD_W-1] ? MAG_W'(11'd1024 - {1'b0, freq_x}) : freq_x;
  assign my = freq_y[COORD_W-1] ? MAG_W'(11'd1024 - {1'b0, freq_y}) : freq_y;

  assign q_full = scale_x ?
      Q_W'(ax2 * aspect) + Q_W'({ay2, 16'b0}) :
      Q_W'({ax2, 16'b0}) + Q_W'(ay2 * aspect);

  assign rem_sh  = {root_rem[REM_W-3:0], root_val[RV_W-1 -: 2]};
  assign trial   = REM_W'({root_res, 2'b01});
  assign res_inc = {1'b0, root_res} + 1'b1;
  assign bin_ext = IW'(res_inc[RES_W:1]);
  assign idx_ext = IW'(idx_r);
  assign rd_addr = kind_r ? idx_ext[AW-1:0] : bin_ext[AW-1:0];
  assign drem_sh = {div_rem[CNT_W-1:0], div_num[SUM_W-1]};

  assign sts.clr_done  = (clr_cnt == (AW+1)'(MAX_BINS));
  assign sts.kind      = kind_r;
  assign sts.root_done = (root_cnt == 4'(ROOT_STEPS));
  assign sts.bin_ok    = (bin_ext < IW'(nbins)) && (bin_ext < BINS_EXT);
  assign sts.cnt_full  = &rd_cnt;
  assign sts.div_done  = (div_cnt == DIVC_W'(SUM_W));

  // single write port shared by clearing, update and read-clear
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = acc_addr;
    wr_data = '0;
    if (cmd.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt[AW-1:0];
    end else if (cmd.acc_wr) begin
      wr_en   = 1'b1;
      wr_data = {SUM_W'(rd_sum + SUM_W'(pw_r)), rd_cnt + 1'b1};
    end else if (cmd.zero_wr) begin
      wr_en = rd_ok;
    end
  end

  // a read beyond the memory reports an empty bin
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.mem_rd) {rd_sum, rd_cnt} <= (kind_r && !rd_ok) ? MW'(0) : mem[rd_addr];
    else if (cmd.load_in) begin
      rd_sum <= '0;
      rd_cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x <= 1'b0;
      aspect  <= ASP_W'(65536);
      nbins   <= NB_W'(512);
      clr_cnt <= '0;
    end else begin
      if (cmd.clr_step) clr_cnt <= clr_cnt + 1'b1;
      if (cfg_we) begin
        case (cfg_index)
          REG_SCALE_X:  scale_x <= cfg_data[0];
          REG_ASPECT:   aspect  <= cfg_data;
          REG_NUM_BINS: nbins   <= cfg_data[NB_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r <= kind;
      ax     <= mx;
      ay     <= my;
      pw_r   <= power;
      idx_r  <= bin_index;
      rd_ok  <= IW'(bin_index) < BINS_EXT;
    end
    if (cmd.do_sq) begin
      ax2 <= SQ_W'(ax * ax);
      ay2 <= SQ_W'(ay * ay);
    end
    if (cmd.do_mul) begin
      root_val <= q_full[Q_W-1:14];
      root_rem <= '0;
      root_res <= '0;
      root_cnt <= '0;
    end else if (cmd.root_step) begin
      root_val <= {root_val[RV_W-3:0], 2'b00};
      root_cnt <= root_cnt + 1'b1;
      if (rem_sh >= trial) begin
        root_rem <= rem_sh - trial;
        root_res <= {root_res[RES_W-2:0], 1'b1};
      end else begin
        root_rem <= rem_sh;
        root_res <= {root_res[RES_W-2:0], 1'b0};
      end
    end
    if (cmd.mem_rd) acc_addr <= rd_addr;
    if (cmd.div_start) begin
      div_num <= rd_sum;
      div_rem <= '0;
      div_q   <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_num <= {div_num[SUM_W-2:0], 1'b0};
      div_cnt <= div_cnt + 1'b1;
      if (drem_sh >= {1'b0, rd_cnt}) begin
        div_rem <= drem_sh - {1'b0, rd_cnt};
        div_q   <= {div_q[SUM_W-2:0], 1'b1};
      end else begin
        div_rem <= drem_sh;
        div_q   <= {div_q[SUM_W-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      bin_average <= (rd_cnt == '0) ? '0 : div_q[PW_W-1:0];
      bin_count   <= rd_cnt;
      bin_echo    <= idx_r;
    end
  end

endmodule

// ===== hw/rtl/radial_power_average.sv =====
// radial_power_average: top level of the rotational power spectrum average
// depends on rpa_pkg, rpa_ctrl and rpa_dp
//
// channel   direction  handshake          payload
// input     in         in_valid/in_stall  kind freq_x freq_y power bin_index
// output    out        out_valid/out_stall bin_average bin_count bin_echo
// config    in         cfg_we             cfg_index cfg_data
//
// accumulate item: accept, square, multiply, root steps, read, update;
// read and update are skipped when the bin is out of use
// read item: accept, square, read, the bit-serial 53-step divider, then result load and bin clear,
// held back while an earlier result waits on out_stall
// after reset a clearing pass zeroes every entry of the bin memory
// the output register lets a new item in while a result waits on out_stall
`timescale 1ns / 1ps
module radial_power_average #(
  parameter int MAX_BINS = rpa_pkg::DEF_MAX_BINS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rpa_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               kind,
  input  logic signed [rpa_pkg::COORD_W-1:0] freq_x,
  input  logic signed [rpa_pkg::COORD_W-1:0] freq_y,
  input  logic [rpa_pkg::PW_W-1:0]           power,
  input  logic [rpa_pkg::IDX_W-1:0]          bin_index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rpa_pkg::PW_W-1:0]           bin_average,
  output logic [rpa_pkg::CNT_W-1:0]          bin_count,
  output logic [rpa_pkg::IDX_W-1:0]          bin_echo
);
  import rpa_pkg::*;

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t sts;

  rpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath holds config registers, bin memory and result register
  rpa_dp #(
    .MAX_BINS (MAX_BINS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .kind        (kind),
    .freq_x      (freq_x),
    .freq_y      (freq_y),
    .power       (power),
    .bin_index   (bin_index),
    .cmd         (cmd),
    .sts         (sts),
    .bin_average (bin_average),
    .bin_count   (bin_count),
    .bin_echo    (bin_echo)
  );

endmodule

// ===== sim/radial_power_average_test.sv =====
// radial_power_average_test: self-checking testbench for the radial power average block
// depends on rpa_pkg and radial_power_average; drives directed rows, then random items
`timescale 1ns / 1ps
module radial_power_average_test;
  import rpa_pkg::*;

  localparam int NBINS     = DEF_MAX_BINS;
  localparam int WATCHDOG  = 20000;
  localparam int SETTLE    = 24;     // long enough for an accumulate item to finish
  localparam int RAND_ITEMS = 1250;
  localparam int PHASES    = 6;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]          cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic                      kind;
  logic signed [COORD_W-1:0] freq_x;
  logic signed [COORD_W-1:0] freq_y;
  logic [PW_W-1:0]           power;
  logic [IDX_W-1:0]          bin_index;
  logic                      out_valid;
  logic                      out_stall;
  logic [PW_W-1:0]           bin_average;
  logic [CNT_W-1:0]          bin_count;
  logic [IDX_W-1:0]          bin_echo;

  radial_power_average dut (.*);

  // one bin report as the block should give it
  typedef struct packed {
    logic [PW_W-1:0]  avg;
    logic [CNT_W-1:0] cnt;
    logic [IDX_W-1:0] echo;
  } report_t;

  // a directed row; typed rows carry their report written out by hand
  typedef struct packed {
    logic                      k;
    logic signed [COORD_W-1:0] fx;
    logic signed [COORD_W-1:0] fy;
    logic [PW_W-1:0]           pw;
    logic [IDX_W-1:0]          idx;
    logic                      typed;
    logic [PW_W-1:0]           avg;
    logic [CNT_W-1:0]          cnt;
  } row_t;

  localparam int NROWS = 16;
  row_t plan [NROWS] = '{
    // read after reset: empty bin
    '{KIND_READ, 10'sd0,    10'sd0,    32'd0,          9'd0,   1'b1, 32'd0,          21'd0},
    // two pixels at the origin, largest and smallest power
    '{KIND_ACC,  10'sd0,    10'sd0,    32'hFFFF_FFFF,  9'd0,   1'b0, 32'd0,          21'd0},
    '{KIND_ACC,  10'sd0,    10'sd0,    32'd0,          9'd0,   1'b0, 32'd0,          21'd0},
    '{KIND_READ, 10'sd0,    10'sd0,    32'd0,          9'd0,   1'b1, 32'h7FFF_FFFF,  21'd2},
    // radius five from both signs
    '{KIND_ACC,  10'sd3,    10'sd4,    32'd100,        9'd0,   1'b0, 32'd0,          21'd0},
    '{KIND_ACC,  -10'sd3,   -10'sd4,   32'd200,        9'd0,   1'b0, 32'd0,          21'd0},
    '{KIND_READ, 10'sd0,    10'sd0,    32'd0,          9'd5,   1'b1, 32'd150,        21'd2},
    // most negative coordinate and the far corner land outside the bins
    '{KIND_ACC,  -10'sd512, 10'sd0,    32'd5,          9'd0,   1'b0, 32'd0,          21'd0},
    '{KIND_ACC,  10'sd511,  10'sd511,  32'd7,          9'd0,   1'b0, 32'd0,          21'd0},
    '{KIND_ACC,  10'sd0,    -10'sd512, 32'd1,          9'd0,   1'b0, 32'd0,          21'd0},
    // last bin in use
    '{KIND_ACC,  -10'sd511, 10'sd0,    32'd9,          9'd0,   1'b0, 32'd0,          21'd0},
    '{KIND_READ, 10'sd0,    10'sd0,    32'd0,          9'd511, 1'b1, 32'd9,          21'd1},
    '{KIND_READ, 10'sd0,    10'sd0,    32'd0,          9'd256, 1'b1, 32'd0,          21'd0},
    // diagonal pixels, checked by the predictor only
    '{KIND_ACC,  10'sd1,    -10'sd1,   32'd10,         9'd0,   1'b0, 32'd0,          21'd0},
    '{KIND_ACC,  10'sd12,   10'sd5,    32'd77,         9'd0,   1'b0, 32'd0,          21'd0},
    '{KIND_READ, 10'sd0,    10'sd0,    32'd0,          9'd13,  1'b0, 32'd0,          21'd0}
  };

  // predictor state: bins and a copy of the registers
  logic [SUM_W-1:0] sum_mem [NBINS];
  logic [CNT_W-1:0] cnt_mem [NBINS];
  logic             cur_scale_x;
  logic [ASP_W-1:0] cur_aspect;
  logic [NB_W-1:0]  cur_bins;

  report_t pending_reports [$];
  int      fail_count;
  int      idle_cycles;
  bit      quiet;        // no idling on either side
  bit      in_accept;
  int      stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // magnitude of a frequency index, -512 taken as 512
  function automatic longint unsigned coord_size(logic [COORD_W-1:0] v);
    if (v[COORD_W-1]) return 64'd1024 - v;
    return v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // radius bin: r^2 in Q.16, rounded half up to an integer
  function automatic longint unsigned radius_bin(logic [COORD_W-1:0] fx,
                                                 logic [COORD_W-1:0] fy);
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned q;
    ax = coord_size(fx);
    ay = coord_size(fy);
    if (cur_scale_x) q = ax * ax * cur_aspect + ((ay * ay) << 16);
    else q = ((ax * ax) << 16) + ay * ay * cur_aspect;
    return (root_floor(q >> 14) + 1) >> 1;
  endfunction

  // applies one accepted item to the bins; a read queues its report
  task automatic bin_update(logic k, logic [COORD_W-1:0] fx, logic [COORD_W-1:0] fy,
                            logic [PW_W-1:0] pw, logic [IDX_W-1:0] idx,
                            bit typed, logic [PW_W-1:0] t_avg, logic [CNT_W-1:0] t_cnt);
    longint unsigned b;
    longint unsigned lim;
    report_t rep;
    if (k == KIND_ACC) begin
      b = radius_bin(fx, fy);
      lim = (cur_bins < NBINS) ? cur_bins : NBINS;
      if (b < lim && cnt_mem[b] != {CNT_W{1'b1}}) begin
        sum_mem[b] = sum_mem[b] + pw;
        cnt_mem[b] = cnt_mem[b] + 1'b1;
      end
    end else begin
      rep.echo = idx;
      rep.cnt  = cnt_mem[idx];
      rep.avg  = (cnt_mem[idx] == 0) ? '0 : PW_W'(sum_mem[idx] / cnt_mem[idx]);
      if (typed) begin
        rep.avg = t_avg;
        rep.cnt = t_cnt;
      end
      sum_mem[idx] = '0;
      cnt_mem[idx] = '0;
      pending_reports.push_back(rep);
    end
  endtask

  // presents one item and holds it until taken; valid is left high for the next one
  task automatic send_item(logic k, logic [COORD_W-1:0] fx, logic [COORD_W-1:0] fy,
                           logic [PW_W-1:0] pw, logic [IDX_W-1:0] idx,
                           bit typed, logic [PW_W-1:0] t_avg, logic [CNT_W-1:0] t_cnt);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    freq_x    <= fx;
    freq_y    <= fy;
    power     <= pw;
    bin_index <= idx;
    do @(posedge clk); while (in_stall);
    bin_update(k, fx, fy, pw, idx, typed, t_avg, t_cnt);
  endtask

  // sender pauses until every report is back and the last pixel has settled
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] ri, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= ri;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_regs(logic sx, logic [ASP_W-1:0] asp, logic [NB_W-1:0] nb);
    write_reg(REG_SCALE_X, CFG_W'(sx));
    write_reg(REG_ASPECT, CFG_W'(asp));
    write_reg(REG_NUM_BINS, CFG_W'(nb));
    cfg_we <= 1'b0;
    cur_scale_x = sx;
    cur_aspect  = asp;
    cur_bins    = nb;
  endtask

  // random coordinate: mostly inside the bins in use, sometimes anywhere
  function automatic logic [COORD_W-1:0] pick_coord(int reach);
    int m;
    if ($urandom_range(0, 7) == 0) return COORD_W'($urandom);
    m = $urandom_range(0, reach);
    return ($urandom_range(0, 1) == 1) ? COORD_W'(-m) : COORD_W'(m);
  endfunction

  function automatic logic [PW_W-1:0] pick_power;
    case ($urandom_range(0, 9))
      0: return '1;
      1: return '0;
      2: return PW_W'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  // output side: random stall bursts and comparison against the oldest report
  always @(posedge clk) begin
    report_t want;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected report: avg %0d count %0d bin %0d",
                     bin_average, bin_count, bin_echo);
        end else begin
          want = pending_reports.pop_front();
          if (bin_average !== want.avg || bin_count !== want.cnt || bin_echo !== want.echo) begin
            fail_count++;
            if (fail_count <= 10)
              $display("bin %0d: expected avg %0d count %0d bin %0d, got avg %0d count %0d bin %0d",
                       want.echo, want.avg, want.cnt, want.echo,
                       bin_average, bin_count, bin_echo);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(0, 5);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: cycles in a row with nothing taken on either channel
  always @(posedge clk) begin
    in_accept = in_valid && !in_stall;
    if (rst || in_accept || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("radial_power_average: mismatch");
      $finish;
    end
  end

  initial begin
    int reach;
    int rd_lim;
    logic k;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    kind       = KIND_ACC;
    freq_x     = '0;
    freq_y     = '0;
    power      = '0;
    bin_index  = '0;
    fail_count = 0;
    idle_cycles = 0;
    quiet      = 1'b0;
    for (int i = 0; i < NBINS; i++) begin
      sum_mem[i] = '0;
      cnt_mem[i] = '0;
    end
    cur_scale_x = 1'b0;
    cur_aspect  = ASP_W'(65536);
    cur_bins    = NB_W'(512);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed rows at the reset settings
    foreach (plan[i])
      send_item(plan[i].k, plan[i].fx, plan[i].fy, plan[i].pw, plan[i].idx,
                plan[i].typed, plan[i].avg, plan[i].cnt);

    // random phases, each with its own register settings, extremes included
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: set_regs(1'b1, ASP_W'(16384), NB_W'(33));
        1: set_regs(1'b0, ASP_W'(0), NB_W'(1));
        2: set_regs(1'b1, ASP_W'(131071), NB_W'(1023));
        3: set_regs(1'b0, ASP_W'(40000), NB_W'(0));
        4: set_regs(1'b1, ASP_W'($urandom_range(1, 131071)), NB_W'($urandom_range(2, 200)));
        default: set_regs(1'b0, ASP_W'(65536), NB_W'(512));
      endcase
      quiet = (ph == PHASES - 1);
      reach  = (cur_bins == 0) ? 40 : ((cur_bins > 360) ? 511 : cur_bins + 4);
      rd_lim = (cur_bins == 0 || cur_bins > 511) ? 511 : cur_bins + 2;
      for (int n = 0; n < RAND_ITEMS / PHASES; n++) begin
        k = ($urandom_range(0, 4) == 0) ? KIND_READ : KIND_ACC;
        send_item(k, pick_coord(reach), pick_coord(reach), pick_power(),
                  ($urandom_range(0, 9) == 0) ? IDX_W'($urandom)
                                              : IDX_W'($urandom_range(0, rd_lim)),
                  1'b0, '0, '0);
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("radial_power_average: match");
    end else begin
      $display("radial_power_average: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rpa_pkg.sv
hw/rtl/rpa_ctrl.sv
hw/rtl/rpa_dp.sv
hw/rtl/radial_power_average.sv
sim/radial_power_average_test.sv
